// ===== hdl/bsfb_pkg.sv =====
`default_nettype none

package bsfb_pkg;

   // Default depth of the queue between the front and the back.
   localparam int FIFO_DEPTH_DEFAULT = 4;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_ID  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_ID   = 3'd4;

   // Output byte positions within the bytes caused by one input item.
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_START  = 4'd0;
   localparam logic [PHASE_W-1:0] PH_CMD    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_STATUS = 4'd2;
   localparam logic [PHASE_W-1:0] PH_SEQ    = 4'd3;
   localparam logic [PHASE_W-1:0] PH_ESC    = 4'd4;
   localparam logic [PHASE_W-1:0] PH_DATA   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_SUM_HI = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SUM_LO = 4'd7;
   localparam logic [PHASE_W-1:0] PH_END    = 4'd8;

   // Configuration register set.
   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
      logic [7:0] escape_byte;
      logic [7:0] command_id;
      logic [7:0] status_id;
   } cfg_type;

   // One classified input item, as handed from the front to the back.
   typedef struct packed {
      logic        hdr;
      logic [7:0]  seq;
      logic        esc;
      logic [7:0]  payload;
      logic        last;
      logic [15:0] csum;
   } desc_type;

   // True when a byte collides with one of the three framing values.
   function automatic logic is_reserved(input cfg_type cfg, input logic [7:0] v);
      return (v == cfg.start_byte) || (v == cfg.end_byte) || (v == cfg.escape_byte);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/byte_stuffed_frame_builder_unit.sv =====
`default_nettype none

// Byte-stuffing frame builder. Each payload byte on the req_ stream (tlast marks
// the final byte of a frame) produces one or more bytes on the rsp_ stream: the
// first byte of a frame is preceded by start byte, command id, status id and a
// sequence number that skips the three framing values; a payload byte that equals
// a framing value goes out as the escape byte and the byte XOR escape; the last
// byte is followed by the 16-bit additive checksum (high, low) and the end byte.
// rsp_tlast marks the last byte caused by one input transfer, rsp_tuser the end
// byte. The output runs at one byte per cycle while rsp_tready is high, through a
// single output register; one input transfer produces 1 to 9 output bytes (1 for a
// plain byte, 2 for an escaped one, plus 4 for a header and 3 for a trailer). The
// front classifies and accepts one transfer per cycle while the queue of FIFO_DEPTH
// entries has room. Write the configuration registers only while the block is idle.
module byte_stuffed_frame_builder_unit #(
   parameter int FIFO_DEPTH = bsfb_pkg::FIFO_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // payload_byte
   input  wire logic                             req_tlast,  // last_byte
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [7:0]                            rsp_tdata,  // out_byte
   output logic                                  rsp_tlast,  // run_last
   output logic                                  rsp_tuser,  // frame_end
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bsfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_data
);
   import bsfb_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push;
   desc_type push_data;
   logic     fifo_full;
   logic     pop;
   logic     head_valid;
   desc_type head_data;

   // Configuration registers; indexes past the list are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_BYTE:  cfg_in.start_byte  = csr_data;
            CSR_END_BYTE:    cfg_in.end_byte    = csr_data;
            CSR_ESCAPE_BYTE: cfg_in.escape_byte = csr_data;
            CSR_COMMAND_ID:  cfg_in.command_id  = csr_data;
            CSR_STATUS_ID:   cfg_in.status_id   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte  <= 8'd240;
         cfg_ff.end_byte    <= 8'd241;
         cfg_ff.escape_byte <= 8'd242;
         cfg_ff.command_id  <= 8'd2;
         cfg_ff.status_id   <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_data  (push_data)
   );

   bsfb_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   bsfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The closing end byte always ends the run of its input transfer.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("end byte not marked as last of its run");

   // The closing end byte carries the configured end value.
   a_end_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == cfg_ff.end_byte))
      else $error("end byte does not match configuration");

   // The front never hands a descriptor to a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ===== hdl/bsfb_front.sv =====
`default_nettype none

module bsfb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsfb_pkg::cfg_type cfg,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,  // payload_byte
   input  wire logic              req_tlast,  // last_byte
   input  wire logic              fifo_full,
   output logic                   push,
   output bsfb_pkg::desc_type     push_data
);
   import bsfb_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] sum_base;
   logic [15:0] sum_new;
   logic [7:0]  seq_next;

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && req_tready;

   // Next sequence number: step past any reserved value, at most four steps.
   always_comb begin
      logic [7:0] s;
      logic       found;
      s     = seq_ff;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!found) begin
            s     = s + 8'd1;
            found = !is_reserved(cfg, s);
         end
      end
      seq_next = s;
   end

   // Running checksum; a new frame starts from the two id bytes.
   assign sum_base = in_frame_ff ? sum_ff
                   : (16'(cfg.command_id) + 16'(cfg.status_id));
   assign sum_new  = sum_base + 16'(req_tdata);

   // Descriptor for the back.
   always_comb begin
      push_data.hdr     = !in_frame_ff;
      push_data.seq     = seq_next;
      push_data.esc     = is_reserved(cfg, req_tdata);
      push_data.payload = req_tdata;
      push_data.last    = req_tlast;
      push_data.csum    = sum_new;
   end

   // Frame state updates on each accepted transfer.
   always_comb begin
      in_frame_in = in_frame_ff;
      seq_in      = seq_ff;
      sum_in      = sum_ff;
      if (push) begin
         in_frame_in = !req_tlast;
         sum_in      = req_tlast ? 16'd0 : sum_new;
         if (!in_frame_ff) begin
            seq_in = seq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         seq_ff      <= 8'd0;
         sum_ff      <= 16'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         seq_ff      <= seq_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bsfb_fifo.sv =====
`default_nettype none

module bsfb_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bsfb_pkg::desc_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output bsfb_pkg::desc_type      head_data
);
   import bsfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bsfb_back.sv =====
`default_nettype none

module bsfb_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bsfb_pkg::cfg_type  cfg,
   input  wire logic               head_valid,
   input  wire bsfb_pkg::desc_type head_data,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,  // out_byte
   output logic                    rsp_tlast,  // run_last
   output logic                    rsp_tuser   // frame_end
);
   import bsfb_pkg::*;

   logic               started_ff, started_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               valid_ff, valid_in;
   logic [7:0]         data_ff, data_in;
   logic               last_ff, last_in;
   logic               user_ff, user_in;
   logic               load;
   logic [PHASE_W-1:0] cur_phase;
   logic [PHASE_W-1:0] next_phase;
   logic               done;
   logic [7:0]         cur_byte;

   assign load = head_valid && (!valid_ff || rsp_tready);
   assign pop  = load && done;

   // The first byte of a fresh descriptor depends on its header and escape flags.
   always_comb begin
      if (started_ff) begin
         cur_phase = phase_ff;
      end else if (head_data.hdr) begin
         cur_phase = PH_START;
      end else if (head_data.esc) begin
         cur_phase = PH_ESC;
      end else begin
         cur_phase = PH_DATA;
      end
   end

   // Byte for the current position and the position that follows it.
   always_comb begin
      cur_byte   = head_data.payload;
      next_phase = PH_DATA;
      done       = 1'b0;
      unique case (cur_phase)
         PH_START: begin
            cur_byte   = cfg.start_byte;
            next_phase = PH_CMD;
         end
         PH_CMD: begin
            cur_byte   = cfg.command_id;
            next_phase = PH_STATUS;
         end
         PH_STATUS: begin
            cur_byte   = cfg.status_id;
            next_phase = PH_SEQ;
         end
         PH_SEQ: begin
            cur_byte   = head_data.seq;
            next_phase = head_data.esc ? PH_ESC : PH_DATA;
         end
         PH_ESC: begin
            cur_byte   = cfg.escape_byte;
            next_phase = PH_DATA;
         end
         PH_DATA: begin
            cur_byte   = head_data.esc ? (head_data.payload ^ cfg.escape_byte)
                                       : head_data.payload;
            next_phase = PH_SUM_HI;
            done       = !head_data.last;
         end
         PH_SUM_HI: begin
            cur_byte   = head_data.csum[15:8];
            next_phase = PH_SUM_LO;
         end
         PH_SUM_LO: begin
            cur_byte   = head_data.csum[7:0];
            next_phase = PH_END;
         end
         PH_END: begin
            cur_byte   = cfg.end_byte;
            next_phase = PH_END;
            done       = 1'b1;
         end
         default: begin
            cur_byte   = head_data.payload;
            next_phase = PH_DATA;
            done       = 1'b1;
         end
      endcase
   end

   // Sequencer position and output register.
   always_comb begin
      started_in = started_ff;
      phase_in   = phase_ff;
      valid_in   = valid_ff;
      data_in    = data_ff;
      last_in    = last_ff;
      user_in    = user_ff;
      if (load) begin
         started_in = !done;
         phase_in   = next_phase;
         valid_in   = 1'b1;
         data_in    = cur_byte;
         last_in    = done;
         user_in    = (cur_phase == PH_END);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         phase_ff   <= PH_START;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         phase_ff   <= phase_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire
